// ----- rtl/sha512_pkg.sv -----
// SHA-512 package: round constants, initial hash value and the sigma functions.
// Used by the streaming hash engine; depends on nothing else.
package sha512_pkg;

  localparam int unsigned WordBits = 64;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned HashWords = 8;
  localparam int unsigned Rounds = 80;

  localparam logic [3:0] FullBytes = 4'd8;
  localparam logic [3:0] LenHiPos = 4'd14;
  localparam logic [3:0] LenLoPos = 4'd15;
  localparam logic [3:0] LastPos = 4'd15;
  localparam logic [6:0] LastRound = 7'(Rounds - 1);
  localparam logic [2:0] LastHashWord = 3'(HashWords - 1);
  localparam logic [WordBits-1:0] PadMarker = 64'h8000_0000_0000_0000;

  localparam logic [WordBits-1:0] HashInit [HashWords] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [WordBits-1:0] RoundK [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [WordBits-1:0] big_sigma0(input logic [WordBits-1:0] x);
    big_sigma0 = {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
  endfunction

  function automatic logic [WordBits-1:0] big_sigma1(input logic [WordBits-1:0] x);
    big_sigma1 = {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
  endfunction

  function automatic logic [WordBits-1:0] small_sigma0(input logic [WordBits-1:0] x);
    small_sigma0 = {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
  endfunction

  function automatic logic [WordBits-1:0] small_sigma1(input logic [WordBits-1:0] x);
    small_sigma1 = {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
  endfunction

  // Keeps the leading valid bytes of a partial word and appends the marker bit.
  function automatic logic [WordBits-1:0] pad_partial(input logic [WordBits-1:0] word,
                                                      input logic [2:0] nbytes);
    logic [5:0] sh;
    sh = {nbytes, 3'b000};
    pad_partial = (word & ~({WordBits{1'b1}} >> sh)) | (PadMarker >> sh);
  endfunction

endpackage

// ----- rtl/sha512_stream_hash.sv -----
// Streaming SHA-512 engine: word packing, padding, 80-round compression and digest output.
// Depends on sha512_pkg for constants and the sigma functions.
//
//   channel   direction  handshake                 payload
//   data      in         data_valid / data_stall   data_word, byte_count, last
//   digest    out        digest_valid / digest_stall  digest_word, word_index, digest_end
//
// A full word is taken while the engine is idle; the sixteenth word of a block starts the compression,
// one round per cycle on a single round unit, during which data stalls.
// The last word adds padding words and one or two compressions, then the
// eight digest words, one per accepted cycle. Reset is synchronous.
// Data stalls from a last word until its final digest word has been taken.
module sha512_stream_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [63:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_end
);
  import sha512_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  state_t        state;
  logic [63:0]   chain [HashWords];
  logic [63:0]   sched [BlockWords];
  logic [63:0]   work [HashWords];
  logic [127:0]  byte_total;
  logic [3:0]    wpos;
  logic [6:0]    rnd;
  logic [2:0]    oidx;
  logic          padding;
  logic          marker_pending;
  logic          len_ok;
  logic          final_blk;

  logic          data_take;
  logic          digest_take;
  logic [3:0]    count_eff;
  logic [63:0]   in_word;
  logic [63:0]   pad_word;
  logic [63:0]   sched_new;
  logic [63:0]   t1;
  logic [63:0]   t2;

  assign data_stall   = (state != ST_IDLE);
  assign data_take    = data_valid && !data_stall;
  assign digest_take  = digest_valid && !digest_stall;
  assign digest_word  = chain[0];
  assign word_index   = oidx;
  assign digest_end   = (oidx == LastHashWord);

  always_comb begin
    if (!last) begin
      count_eff = FullBytes;
    end else if (byte_count > FullBytes) begin
      count_eff = FullBytes;
    end else begin
      count_eff = byte_count;
    end
    if (count_eff == FullBytes) begin
      in_word = data_word;
    end else begin
      in_word = pad_partial(data_word, count_eff[2:0]);
    end
    if (marker_pending) begin
      pad_word = PadMarker;
    end else if (len_ok && wpos == LenHiPos) begin
      pad_word = byte_total[124:61];
    end else if (len_ok && wpos == LenLoPos) begin
      pad_word = {byte_total[60:0], 3'b000};
    end else begin
      pad_word = '0;
    end
    sched_new = small_sigma1(sched[14]) + sched[9] + small_sigma0(sched[1]) + sched[0];
    t1 = work[7] + big_sigma1(work[4]) + ((work[4] & work[5]) ^ (~work[4] & work[6]))
       + RoundK[rnd] + sched[0];
    t2 = big_sigma0(work[0])
       + ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      byte_total     <= '0;
      wpos           <= '0;
      rnd            <= '0;
      oidx           <= '0;
      padding        <= 1'b0;
      marker_pending <= 1'b0;
      len_ok         <= 1'b0;
      final_blk      <= 1'b0;
      digest_valid   <= 1'b0;
      for (int i = 0; i < HashWords; i++) begin
        chain[i] <= HashInit[i];
      end
    end else begin
      case (state)
        ST_IDLE: begin
          for (int i = 0; i < HashWords; i++) begin
            work[i] <= chain[i];
          end
          if (data_take) begin
            for (int i = 0; i < BlockWords - 1; i++) begin
              sched[i] <= sched[i + 1];
            end
            sched[BlockWords - 1] <= in_word;
            byte_total <= byte_total + 128'(count_eff);
            wpos <= wpos + 4'd1;
            rnd <= '0;
            final_blk <= 1'b0;
            padding <= last;
            marker_pending <= last && (count_eff == FullBytes);
            len_ok <= last && (count_eff != FullBytes) && (wpos < LenHiPos);
            if (wpos == LastPos) begin
              state <= ST_ROUND;
            end else if (last) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          for (int i = 0; i < HashWords; i++) begin
            work[i] <= chain[i];
          end
          for (int i = 0; i < BlockWords - 1; i++) begin
            sched[i] <= sched[i + 1];
          end
          sched[BlockWords - 1] <= pad_word;
          wpos <= wpos + 4'd1;
          rnd <= '0;
          if (marker_pending) begin
            marker_pending <= 1'b0;
            len_ok <= (wpos < LenHiPos);
          end
          if (wpos == LastPos) begin
            final_blk <= len_ok && !marker_pending;
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          for (int i = 0; i < BlockWords - 1; i++) begin
            sched[i] <= sched[i + 1];
          end
          sched[BlockWords - 1] <= sched_new;
          work[7] <= work[6];
          work[6] <= work[5];
          work[5] <= work[4];
          work[4] <= work[3] + t1;
          work[3] <= work[2];
          work[2] <= work[1];
          work[1] <= work[0];
          work[0] <= t1 + t2;
          rnd <= rnd + 7'd1;
          if (rnd == LastRound) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < HashWords; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          if (final_blk) begin
            oidx <= '0;
            digest_valid <= 1'b1;
            state <= ST_OUT;
          end else if (padding) begin
            len_ok <= !marker_pending;
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (digest_take) begin
            for (int i = 0; i < HashWords - 1; i++) begin
              chain[i] <= chain[i + 1];
            end
            chain[HashWords - 1] <= HashInit[oidx];
            oidx <= oidx + 3'd1;
            if (oidx == LastHashWord) begin
              digest_valid <= 1'b0;
              byte_total <= '0;
              padding <= 1'b0;
              final_blk <= 1'b0;
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // No new item is taken while a digest is still being delivered.
  a_no_take_during_digest: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> data_stall)
    else $error("data item accepted while digest pending");

  // Every compression starts on a block boundary.
  a_round_start_aligned: assert property (@(posedge clk) disable iff (rst)
    (state != ST_ROUND) ##1 (state == ST_ROUND) |-> (wpos == '0) && (rnd == '0))
    else $error("compression started off a block boundary");

  // The round counter never runs past the last round.
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (rnd <= LastRound))
    else $error("round counter out of range");

  // After the final digest word the engine is back at the start of a message.
  a_restart_after_digest: assert property (@(posedge clk) disable iff (rst)
    digest_take && digest_end |=> (byte_total == '0) && (wpos == '0)
      && (chain[0] == HashInit[0]) && !digest_valid)
    else $error("state not restored after digest");

  // Padding only writes the length after the marker has been placed.
  a_len_after_marker: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAD) && len_ok |-> !marker_pending)
    else $error("length field written before the marker");

endmodule

// ----- dv/tb_sha512_stream_hash.sv -----
// Testbench for sha512_stream_hash: directed messages, two with known digests, then random messages.
// Predicts the other digests with its own SHA-512 model and checks each output word in order.
// Depends only on the RTL under rtl/ (sha512_pkg and sha512_stream_hash).
module tb_sha512_stream_hash;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [511:0] EmptyDigest = {
    64'hcf83e1357eefb8bd, 64'hf1542850d66d8007, 64'hd620e4050b5715dc, 64'h83f4a921d36ce9ce,
    64'h47d0d13c5d85f2b0, 64'hff8318d2877eec2f, 64'h63b931bd47417a81, 64'ha538327af927da3e
  };
  localparam logic [511:0] AbcDigest = {
    64'hddaf35a193617aba, 64'hcc417349ae204131, 64'h12e6fa4e89a97ea2, 64'h0a9eeee64b55d39a,
    64'h2192992a274fc1a8, 64'h36ba3c23a3feebbd, 64'h454d4423643ce80e, 64'h2a9ac94fa54ca49f
  };
  localparam logic [63:0] AllOnes = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] MarkerBit = 64'h8000_0000_0000_0000;
  localparam logic [3:0] FullWord = 4'd8;
  localparam int RandomWords = 350;

  localparam logic [63:0] ShaK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };
  localparam logic [63:0] ShaInit [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  typedef struct {
    logic [63:0] word;
    logic [2:0]  index;
    logic        tail;
  } digest_beat_t;

  typedef struct {
    logic [63:0]  word;
    logic [3:0]   count;
    logic         fin;
    logic         known;
    logic [511:0] digest;
  } msg_row_t;

  logic        clk;
  logic        rst;
  logic        data_valid;
  logic        data_stall;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last;
  logic        digest_valid;
  logic        digest_stall;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_end;

  logic [63:0]  chain_h [8];
  logic [63:0]  block_w [16];
  logic [127:0] msg_bytes;
  digest_beat_t pending_digest_words [$];
  msg_row_t     directed_rows [$];
  int           fail_count = 0;
  bit           calm = 1'b0;

  sha512_stream_hash u_top (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .last         (last),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .digest_end   (digest_end)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("sha512_stream_hash verification failed");
    $finish;
  end

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
  endtask

  task automatic compress_block();
    logic [63:0] w [16];
    logic [63:0] v [8];
    logic [63:0] a2, a15, wr, t1, t2;
    int r;
    w = block_w;
    v = chain_h;
    for (r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        a2 = w[(r - 2) & 15];
        a15 = w[(r - 15) & 15];
        wr = (rotr(a2, 19) ^ rotr(a2, 61) ^ (a2 >> 6)) + w[(r - 7) & 15]
           + (rotr(a15, 1) ^ rotr(a15, 8) ^ (a15 >> 7)) + w[r & 15];
        w[r & 15] = wr;
      end
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ShaK[r] + wr;
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (r = 0; r < 8; r++) chain_h[r] = chain_h[r] + v[r];
  endtask

  // Takes one accepted word into the running hash; on a last word returns the digest.
  task automatic absorb_word(input logic [63:0] word, input logic [3:0] count,
                             input logic fin, output logic done, output logic [511:0] dig);
    int pos;
    int n;
    int k;
    logic [127:0] bit_len;
    done = 1'b0;
    dig = '0;
    pos = int'(msg_bytes[6:3]);
    if (!fin) begin
      block_w[pos] = word;
      msg_bytes = msg_bytes + 128'd8;
      if (pos == 15) compress_block();
      return;
    end
    n = (count > FullWord) ? 8 : int'(count);
    msg_bytes = msg_bytes + 128'(n);
    if (n == 8) begin
      block_w[pos] = word;
      pos++;
      if (pos == 16) begin
        compress_block();
        pos = 0;
      end
      block_w[pos] = MarkerBit;
    end else begin
      block_w[pos] = (word & ~(AllOnes >> (n * 8))) | (64'h80 << (56 - n * 8));
    end
    pos++;
    if (pos > 14) begin
      while (pos < 16) begin
        block_w[pos] = '0;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 14) begin
      block_w[pos] = '0;
      pos++;
    end
    bit_len = msg_bytes << 3;
    block_w[14] = bit_len[127:64];
    block_w[15] = bit_len[63:0];
    compress_block();
    for (k = 0; k < 8; k++) dig[511 - 64 * k -: 64] = chain_h[k];
    done = 1'b1;
    chain_h = ShaInit;
    msg_bytes = '0;
  endtask

  task automatic send_word(input msg_row_t row);
    logic done;
    logic [511:0] dig;
    digest_beat_t beat;
    int k;
    while (!calm && $urandom_range(99) < 17) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_word <= row.word;
    byte_count <= row.count;
    last <= row.fin;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    absorb_word(row.word, row.count, row.fin, done, dig);
    if (done) begin
      if (row.known) dig = row.digest;
      for (k = 0; k < 8; k++) begin
        beat.word = dig[511 - 64 * k -: 64];
        beat.index = 3'(k);
        beat.tail = (k == 7);
        pending_digest_words.push_back(beat);
      end
    end
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return AllOnes;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst && digest_valid && !digest_stall) begin
      if (pending_digest_words.size() == 0) begin
        report_mismatch("digest word with none expected", digest_word, '0);
      end else begin
        want = pending_digest_words.pop_front();
        if (digest_word !== want.word)
          report_mismatch($sformatf("digest_word %0d", want.index), digest_word, want.word);
        if (word_index !== want.index)
          report_mismatch("word_index", 64'(word_index), 64'(want.index));
        if (digest_end !== want.tail)
          report_mismatch("digest_end", 64'(digest_end), 64'(want.tail));
      end
    end
    digest_stall <= !calm && ($urandom_range(99) < 17);
  end

  initial begin
    msg_row_t row;
    int i;
    int m;
    int n;
    int sel;
    int sent;
    rst <= 1'b1;
    data_valid <= 1'b0;
    data_word <= '0;
    byte_count <= '0;
    last <= 1'b0;
    chain_h = ShaInit;
    block_w = '{default: '0};
    msg_bytes = '0;

    directed_rows.push_back('{64'h0, 4'd0, 1'b1, 1'b1, EmptyDigest});
    directed_rows.push_back('{64'h6162_63ff_ffff_ffff, 4'd3, 1'b1, 1'b1, AbcDigest});
    directed_rows.push_back('{AllOnes, 4'd15, 1'b1, 1'b0, '0});
    directed_rows.push_back('{64'h0123_4567_89ab_cdef, 4'd0, 1'b0, 1'b0, '0});
    directed_rows.push_back('{AllOnes, 4'd9, 1'b0, 1'b0, '0});
    directed_rows.push_back('{AllOnes, 4'd0, 1'b1, 1'b0, '0});
    directed_rows.push_back('{64'h0, FullWord, 1'b1, 1'b0, '0});
    for (i = 0; i < 14; i++)
      directed_rows.push_back('{(i % 2 == 0) ? AllOnes : 64'ha5a5_5a5a_0000_0000 + 64'(i),
                                FullWord, 1'b0, 1'b0, '0});
    directed_rows.push_back('{64'hfedc_ba98_7654_3210, 4'd7, 1'b1, 1'b0, '0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[j]) send_word(directed_rows[j]);

    // Random part: whole messages, lengths weighted toward block boundaries.
    sent = 0;
    for (m = 0; sent < RandomWords; m++) begin
      calm = (m >= 8 && m < 14);
      sel = $urandom_range(99);
      if (sel < 55) n = $urandom_range(0, 17);
      else if (sel < 85) n = 16 * $urandom_range(0, 1) + $urandom_range(13, 16);
      else n = $urandom_range(18, 40);
      for (i = 0; i < n; i++) begin
        row = '{pick_word(), 4'($urandom_range(0, 15)), 1'b0, 1'b0, '0};
        if ($urandom_range(3) != 0) row.count = FullWord;
        send_word(row);
        sent++;
      end
      sel = $urandom_range(99);
      row = '{pick_word(), FullWord, 1'b1, 1'b0, '0};
      if (sel < 70) row.count = 4'($urandom_range(0, 8));
      else if (sel >= 85) row.count = 4'($urandom_range(9, 15));
      send_word(row);
      sent++;
    end
    calm = 1'b0;
    data_valid <= 1'b0;

    while (pending_digest_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("sha512_stream_hash verification clean");
    end else begin
      $display("sha512_stream_hash verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sha512_pkg.sv
rtl/sha512_stream_hash.sv
dv/tb_sha512_stream_hash.sv
